>>> design/hmpq_pkg.sv
// Shared definitions for the binary max-heap priority queue.
// Capacity, derived widths, entry layout, operation codes and controller states.
// No dependencies.
package hmpq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CHILD_W   = ADDR_W + 2;
  localparam int DATA_W    = 32;
  localparam int OUT_CNT_W = 11;

  localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1337;

  typedef struct packed {
    logic signed [DATA_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PEEK   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DONE,
    S_UP_CMP,
    S_UP_FIN,
    S_DN_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R
  } state_e;

endpackage

>>> design/hmpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hmpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/binary_max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue: controller and heap memory.
// Depends on hmpq_pkg and hmpq_ram.
//
// One command beat is taken when start is high and busy is low; each command
// yields exactly one result beat, marked by done_o for one cycle, which the
// receiver must take there and then. A peek or a refused command gives its
// result in the cycle after the command. An insert sifts the new entry up, comparing
// it with one parent per level; a removal moves the last entry to the root and sifts
// it down, reading the left child and then the right child at each level, since the
// single read port of the heap memory has to fetch the two children one after the
// other. A new command can be given in the cycle the result is shown. The heap
// memory is not cleared at reset; only entries below the count are ever read.
module binary_max_heap_priority_queue
  import hmpq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic [1:0]                 func_i,
  input  logic signed [DATA_W-1:0]   priority_req_i,
  input  logic signed [DATA_W-1:0]   payload_i,
  output logic                       busy,
  output logic                       done_o,
  output logic                       status_o,
  output logic signed [DATA_W-1:0]   top_data_o,
  output logic                       is_empty_o,
  output logic [OUT_CNT_W-1:0]       entry_count_o
);

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   idx_q, idx_d;
  entry_t              ent_q, ent_d;
  entry_t              lch_q, lch_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DATA_W-1:0]   root_q, root_d;
  logic                status_q, status_d;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  entry_t              ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  entry_t              ram_rdata;

  logic [CHILD_W-1:0]  left_w, right_w, cnt_ext;
  logic                pick_left;
  entry_t              best_ent;
  logic [ADDR_W-1:0]   best_idx;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;

  function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] i);
    return (i - ADDR_W'(1)) >> 1;
  endfunction

  hmpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign left_w    = {1'b0, idx_q, 1'b1};
  assign right_w   = left_w + CHILD_W'(1);
  assign cnt_ext   = CHILD_W'(cnt_q);
  // ties between children go right
  assign pick_left = lch_q.prio > ram_rdata.prio;
  assign best_ent  = pick_left ? lch_q : ram_rdata;
  assign best_idx  = pick_left ? left_w[ADDR_W-1:0] : right_w[ADDR_W-1:0];

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    ent_d     = ent_q;
    lch_d     = lch_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ent_q;
    ram_raddr = '0;
    unique case (state_q)
      S_IDLE, S_DONE: begin
        state_d = S_IDLE;
        if (start) begin
          status_d = 1'b0;
          priority if (func_i == FUNC_INSERT) begin
            if (cnt_q >= CNT_W'(CAPACITY)) begin
              status_d = 1'b1;
              state_d  = S_DONE;
            end else begin
              ent_d = '{prio: priority_req_i, data: payload_i};
              idx_d = cnt_q[ADDR_W-1:0];
              cnt_d = cnt_q + CNT_W'(1);
              if (cnt_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{prio: priority_req_i, data: payload_i};
                state_d   = S_DONE;
              end else begin
                ram_raddr = parent_of(cnt_q[ADDR_W-1:0]);
                state_d   = S_UP_CMP;
              end
            end
          end else if (func_i == FUNC_REMOVE) begin
            if (cnt_q == '0) begin
              status_d = 1'b1;
              state_d  = S_DONE;
            end else begin
              ram_raddr = ADDR_W'(cnt_q - CNT_W'(1));
              cnt_d     = cnt_q - CNT_W'(1);
              idx_d     = '0;
              state_d   = S_DN_LAST;
            end
          end else begin
            status_d = (cnt_q == '0);
            state_d  = S_DONE;
          end
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ent_q.prio > ram_rdata.prio) begin
          ram_wdata = ram_rdata;
          idx_d     = parent_of(idx_q);
          if (parent_of(idx_q) == '0) begin
            state_d = S_UP_FIN;
          end else begin
            ram_raddr = parent_of(parent_of(idx_q));
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_UP_FIN: begin
        ram_we  = 1'b1;
        state_d = S_DONE;
      end
      S_DN_LAST: begin
        ent_d   = ram_rdata;
        state_d = (cnt_q == '0) ? S_DONE : S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_w >= cnt_ext) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_raddr = left_w[ADDR_W-1:0];
          state_d   = S_DN_L;
        end
      end
      S_DN_L: begin
        lch_d = ram_rdata;
        if (right_w < cnt_ext) begin
          ram_raddr = right_w[ADDR_W-1:0];
          state_d   = S_DN_R;
        end else if (ent_q.prio < ram_rdata.prio) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          idx_d     = left_w[ADDR_W-1:0];
          state_d   = S_DN_CHK;
        end else begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DN_R: begin
        ram_we = 1'b1;
        if (ent_q.prio < best_ent.prio) begin
          ram_wdata = best_ent;
          idx_d     = best_idx;
          state_d   = S_DN_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // shadow of the root's data
    root_d = (ram_we && ram_waddr == '0) ? ram_wdata.data : root_q;
  end

  assign cnt_wide = {{OUT_CNT_W{1'b0}}, cnt_q};

  always_comb begin
    busy          = !(state_q == S_IDLE || state_q == S_DONE);
    done_o        = (state_q == S_DONE);
    status_o      = status_q;
    is_empty_o    = (cnt_q == '0);
    top_data_o    = is_empty_o ? EMPTY_DATA : root_q;
    entry_count_o = cnt_wide[OUT_CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    ent_q  <= ent_d;
    lch_q  <= lch_d;
    root_q <= root_d;
  end

endmodule

>>> design/hmpq_checker.sv
// Port-level checks for the binary max-heap priority queue, bound to the top level.
// Depends on hmpq_pkg and binary_max_heap_priority_queue.
module hmpq_checker
  import hmpq_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic [1:0]               func_i,
  input logic                     busy,
  input logic                     done_o,
  input logic                     status_o,
  input logic signed [DATA_W-1:0] top_data_o,
  input logic                     is_empty_o,
  input logic [OUT_CNT_W-1:0]     entry_count_o
);

  // a result beat never coincides with busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  // no result beat without a command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !done_o && !start) |=> !done_o)
    else $error("result beat without a command");

  // work ends only in a result beat
  a_busy_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (busy || done_o))
    else $error("command dropped without a result");

  a_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (top_data_o == EMPTY_DATA && entry_count_o == '0))
    else $error("empty result carries data or a count");

  // peek (or the spare code) on an empty queue must fail
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o && $past(start) && $past(!busy)
     && $past(func_i) != FUNC_INSERT && $past(func_i) != FUNC_REMOVE) |-> status_o)
    else $error("peek on empty queue reported success");

endmodule

bind binary_max_heap_priority_queue hmpq_checker u_hmpq_checker (.*);

>>> tb/binary_max_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_max_heap_priority_queue: drives insert, remove,
// peek and spare-code commands and checks every result beat against a heap kept in a
// scoreboard class. Depends on hmpq_pkg and the RTL top level.
module binary_max_heap_priority_queue_tb;
  import hmpq_pkg::*;

  localparam logic [1:0] FUNC_SPARE    = 2'd3;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         IDLE_PCT [3]  = '{0, 81, 29};

  typedef struct {
    logic                     status;
    logic signed [DATA_W-1:0] top;
    logic                     empty;
    logic [OUT_CNT_W-1:0]     count;
  } outcome_t;

  class heap_tracker;
    entry_t      slots [CAPACITY];
    int unsigned fill;
    outcome_t    awaited [$];
    int          errors, commands, checked, peak, full_refusals, empty_refusals;

    function new();
      fill = 0;
      errors = 0;
      commands = 0;
      checked = 0;
      peak = 0;
      full_refusals = 0;
      empty_refusals = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      entry_t t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void lift(int unsigned idx);
      int unsigned parent;
      while (idx > 0) begin
        parent = (idx - 1) / 2;
        if ($signed(slots[idx].prio) > $signed(slots[parent].prio)) begin
          swap_slots(idx, parent);
          idx = parent;
        end else begin
          break;
        end
      end
    endfunction

    // ties between the two children go to the right one
    function void sink(int unsigned idx);
      int unsigned left, right, best;
      forever begin
        left = 2 * idx + 1;
        right = left + 1;
        if (left >= fill) break;
        best = left;
        if (right < fill && !($signed(slots[left].prio) > $signed(slots[right].prio)))
          best = right;
        if ($signed(slots[idx].prio) < $signed(slots[best].prio)) begin
          swap_slots(idx, best);
          idx = best;
        end else begin
          break;
        end
      end
    endfunction

    function void predict_command(logic [1:0] op, logic signed [DATA_W-1:0] prio,
                                  logic signed [DATA_W-1:0] data);
      outcome_t o;
      o.status = 1'b0;
      commands++;
      case (op)
        FUNC_INSERT: begin
          if (fill >= CAPACITY) begin
            o.status = 1'b1;
            full_refusals++;
          end else begin
            slots[fill] = '{prio: prio, data: data};
            fill++;
            lift(fill - 1);
          end
        end
        FUNC_REMOVE: begin
          if (fill == 0) begin
            o.status = 1'b1;
            empty_refusals++;
          end else begin
            slots[0] = slots[fill - 1];
            fill--;
            sink(0);
          end
        end
        default: begin
          if (fill == 0) begin
            o.status = 1'b1;
            empty_refusals++;
          end
        end
      endcase
      if (fill > peak) peak = fill;
      o.empty = (fill == 0);
      o.top   = o.empty ? EMPTY_DATA : slots[0].data;
      o.count = OUT_CNT_W'(fill);
      awaited.push_back(o);
    endfunction

    function void compare_outcome(logic st, logic signed [DATA_W-1:0] top, logic emp,
                                  logic [OUT_CNT_W-1:0] cnt);
      outcome_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected (status %0b top %0d count %0d)",
                 $time, st, top, cnt);
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (st !== e.status) begin
        errors++;
        $display("%0t: status expected %0b actual %0b", $time, e.status, st);
      end
      if (top !== e.top) begin
        errors++;
        $display("%0t: top_data expected %0d actual %0d", $time, e.top, top);
      end
      if (emp !== e.empty) begin
        errors++;
        $display("%0t: is_empty expected %0b actual %0b", $time, e.empty, emp);
      end
      if (cnt !== e.count) begin
        errors++;
        $display("%0t: entry_count expected %0d actual %0d", $time, e.count, cnt);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start;
  logic [1:0]                 func_i;
  logic signed [DATA_W-1:0]   priority_req_i;
  logic signed [DATA_W-1:0]   payload_i;
  logic                       busy;
  logic                       done_o;
  logic                       status_o;
  logic signed [DATA_W-1:0]   top_data_o;
  logic                       is_empty_o;
  logic [OUT_CNT_W-1:0]       entry_count_o;

  heap_tracker tracker;
  int          cycle_cnt = 0;
  int          idle_pct = 0;

  binary_max_heap_priority_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .func_i         (func_i),
    .priority_req_i (priority_req_i),
    .payload_i      (payload_i),
    .busy           (busy),
    .done_o         (done_o),
    .status_o       (status_o),
    .top_data_o     (top_data_o),
    .is_empty_o     (is_empty_o),
    .entry_count_o  (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && done_o)
      tracker.compare_outcome(status_o, top_data_o, is_empty_o, entry_count_o);
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d results still outstanding", $time, tracker.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 4) - 2;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int ins_pct, int rem_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return FUNC_INSERT;
    if (r < ins_pct + rem_pct) return FUNC_REMOVE;
    return $urandom_range(0, 1) ? FUNC_PEEK : FUNC_SPARE;
  endfunction

  // beat is taken at the edge where start is high and busy low
  task automatic issue(input logic [1:0] op, input logic signed [DATA_W-1:0] prio,
                       input logic signed [DATA_W-1:0] data);
    start          <= 1'b1;
    func_i         <= op;
    priority_req_i <= prio;
    payload_i      <= data;
    do @(posedge clk_i); while (busy);
    tracker.predict_command(op, prio, data);
  endtask

  task automatic pause_sender();
    int n;
    n = 0;
    while (n < 60 && $urandom_range(0, 99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_item(input logic [1:0] op);
    pause_sender();
    issue(op, pick_priority(), $urandom);
  endtask

  initial begin
    int n;
    tracker = new();
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    func_i         <= FUNC_PEEK;
    priority_req_i <= '0;
    payload_i      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty refusals, extreme fields, equal priorities, tie to the right
    issue(FUNC_PEEK,   32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(FUNC_REMOVE, 32'h8000_0000, 32'h8000_0000);
    issue(FUNC_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(FUNC_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    issue(FUNC_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(FUNC_INSERT, 32'h7FFF_FFFF, 32'h1111_1111);
    issue(FUNC_PEEK,   32'h0000_0000, 32'h0000_0000);
    issue(FUNC_SPARE,  32'h0000_0000, 32'h0000_0000);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_INSERT, 32'd10, 32'hA000_000A);
    issue(FUNC_INSERT, 32'd5,  32'hB000_000B);
    issue(FUNC_INSERT, 32'd5,  32'hC000_000C);
    issue(FUNC_INSERT, 32'd1,  32'hD000_000D);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue(FUNC_PEEK,   32'h0000_0000, 32'h0000_0000);

    // mixed traffic, idling changes every 30 beats
    for (n = 0; n < 180; n++) begin
      idle_pct = IDLE_PCT[(n / 30) % 3];
      random_item(pick_op(50, 40));
      if (n == 89) hold_until_drained();
    end

    // fill to capacity, then refused inserts, a peek and a spare code
    n = 0;
    while (tracker.fill < CAPACITY) begin
      idle_pct = IDLE_PCT[(n / 100) % 3];
      random_item(FUNC_INSERT);
      n++;
    end
    idle_pct = 0;
    repeat (3) random_item(FUNC_INSERT);
    random_item(FUNC_PEEK);
    random_item(FUNC_SPARE);

    // drain to empty with peeks mixed in, checking heap order on every removal; then refused removals and a peek
    n = 0;
    while (tracker.fill > 0) begin
      idle_pct = IDLE_PCT[(n / 100) % 3];
      random_item($urandom_range(0, 9) == 0 ? FUNC_PEEK : FUNC_REMOVE);
      n++;
    end
    idle_pct = 0;
    repeat (2) random_item(FUNC_REMOVE);
    random_item(FUNC_PEEK);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands, %0d results checked, peak occupancy %0d of %0d entries",
             tracker.commands, tracker.checked, tracker.peak, CAPACITY);
    $display("Refused %0d inserts on a full queue and %0d removes/peeks on an empty one",
             tracker.full_refusals, tracker.empty_refusals);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
